>>> hw/rtl/assert_macros.svh
// Assertion shorthands for the breath activity volume block.
// Both expect a clock named clk; the first is held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset
`define BAV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included
`define BAV_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bav_pkg.sv
package bav_pkg;

	// Default depth of the activity ring
	localparam int WINDOW_SIZE = 32;

	// Field widths
	localparam int SAMPLE_W  = 12;
	localparam int TIME_W    = 64;
	localparam int DATA_W    = 16;
	localparam int GAIN_W    = 5;
	localparam int COUNT_W   = 9;
	localparam int CFG_IDX_W = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_VOL  = 3'd4;

	// Register reset values
	localparam logic [GAIN_W-1:0]  GAIN_RST      = 5'd1;
	localparam logic [DATA_W-1:0]  THRESHOLD_RST = 16'd100;
	localparam logic [COUNT_W-1:0] FLOOR_RST     = 9'd4;
	localparam logic [COUNT_W-1:0] CEILING_RST   = 9'd20;
	localparam logic [DATA_W-1:0]  FULL_VOL_RST  = 16'd16;

	// Rate when no time has elapsed
	localparam logic [DATA_W-1:0] RATE_MAX = '1;

	// Divider request
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	// Activity ring request
	typedef struct packed {
		logic rd;
		logic wr;
		logic flag;
	} ring_req_t;

endpackage

>>> hw/rtl/bav_div.sv
// Restoring divider, one quotient bit per cycle. Divisor must be non-zero.
module bav_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bav_pkg::div_req_t           req,
	output logic                        done,
	output logic [bav_pkg::DATA_W-1:0]  quotient
);

	localparam int DW    = bav_pkg::DATA_W;
	localparam int CNT_W = $clog2(DW);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    dvs_q;
	logic [DW:0]      shifted;
	logic [DW:0]      trial;

	// Shift in next dividend bit and try the subtraction
	assign shifted = {rem_q, quo_q[DW-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath; borrow out of the trial means restore
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (trial[DW]) begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hw/rtl/bav_ring.sv
// Ring of activity flags. Read is issued ahead of the write of the same item
// and returns the flag in the slot after the write position.
module bav_ring #(
	parameter int WINDOW_SIZE = bav_pkg::WINDOW_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bav_pkg::ring_req_t req,
	output logic               old_flag
);

	localparam int POS_W = $clog2(WINDOW_SIZE);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_SIZE - 1);

	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       nxt;
	logic [WINDOW_SIZE-1:0] valid_q;
	logic                   flag_mem [WINDOW_SIZE];
	logic                   old_flag_q;

	assign nxt = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;

	// Write position and per-slot valid bits; unwritten slots read as clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= '0;
		end else if (req.wr) begin
			valid_q[pos_q] <= 1'b1;
			pos_q          <= nxt;
		end
	end

	// Flag store
	always_ff @(posedge clk) begin
		if (req.wr)
			flag_mem[pos_q] <= req.flag;
		if (req.rd)
			old_flag_q <= flag_mem[nxt] & valid_q[nxt];
	end

	assign old_flag = old_flag_q;

endmodule

>>> hw/rtl/breath_activity_volume.sv
// Breath activity volume.
// Input channel (in_valid/in_ready) takes one converter sample with its
// microsecond timestamp per transaction; output channel (out_valid/out_ready)
// returns one volume per input, in order. Registers are written through
// cfg_wen/cfg_index/cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. Each transaction is
// worked one at a time: the sample is scaled as it is taken, a set-up state
// starts the restoring divider, the change rate is collected when it is
// done, then the activity ring and count are updated and the volume
// registered. The divider is skipped when elapsed time is zero or exceeds
// 16 bits. in_ready returns high the cycle the volume is registered, so a
// new sample is taken only once the last one's volume is registered.
// The output register holds a volume while the receiver stalls; the next
// input may be taken meanwhile, and its update waits until the register
// frees. Reset clears all registers to their defaults, empties the
// activity ring, zeroes the previous sample and time and drops out_valid.
module breath_activity_volume #(
	parameter int WINDOW_SIZE = bav_pkg::WINDOW_SIZE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [bav_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bav_pkg::DATA_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bav_pkg::SAMPLE_W-1:0]   sample,
	input  logic [bav_pkg::TIME_W-1:0]     timestamp_us,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bav_pkg::DATA_W-1:0]     volume
);

	localparam int DW  = bav_pkg::DATA_W;
	localparam int TW  = bav_pkg::TIME_W;
	localparam int CW  = bav_pkg::COUNT_W;
	localparam int PW  = bav_pkg::SAMPLE_W + bav_pkg::GAIN_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	// Configuration registers
	logic [bav_pkg::GAIN_W-1:0] gain_q;
	logic [DW-1:0]              thr_q;
	logic [CW-1:0]              floor_q;
	logic [CW-1:0]              ceil_q;
	logic [DW-1:0]              full_q;

	logic [1:0]    state_q;
	logic [DW-1:0] scaled_q;
	logic [TW-1:0] time_q;
	logic [DW-1:0] prev_sample_q;
	logic [TW-1:0] prev_time_q;
	logic [CW-1:0] count_q;
	logic [DW-1:0] rate_q;
	logic          out_valid_q;
	logic [DW-1:0] volume_q;

	logic          in_fire;
	logic [PW-1:0] product;
	logic [DW-1:0] delta;
	logic [TW-1:0] elapsed;
	logic          no_time;
	logic          too_long;
	logic          out_free;
	logic          upd_fire;
	logic          active;
	logic          old_flag;
	logic [CW-1:0] count_next;
	logic [CW-1:0] over_floor;
	logic [DW-1:0] volume_next;
	logic          div_done;
	logic [DW-1:0] quotient;

	bav_pkg::div_req_t  div_req;
	bav_pkg::ring_req_t ring_req;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= bav_pkg::GAIN_RST;
			thr_q   <= bav_pkg::THRESHOLD_RST;
			floor_q <= bav_pkg::FLOOR_RST;
			ceil_q  <= bav_pkg::CEILING_RST;
			full_q  <= bav_pkg::FULL_VOL_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				bav_pkg::REG_GAIN:      gain_q  <= cfg_data[bav_pkg::GAIN_W-1:0];
				bav_pkg::REG_THRESHOLD: thr_q   <= cfg_data;
				bav_pkg::REG_FLOOR:     floor_q <= cfg_data[CW-1:0];
				bav_pkg::REG_CEILING:   ceil_q  <= cfg_data[CW-1:0];
				bav_pkg::REG_FULL_VOL:  full_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Gain, truncated to 16 bits
	assign product = PW'(sample) * PW'(gain_q);

	// Change and elapsed time
	assign delta    = (scaled_q >= prev_sample_q) ? scaled_q - prev_sample_q
	                                              : prev_sample_q - scaled_q;
	assign elapsed  = time_q - prev_time_q;
	assign no_time  = (time_q == prev_time_q);
	assign too_long = |elapsed[TW-1:DW];

	// Divider request
	always_comb begin
		div_req          = '0;
		div_req.start    = (state_q == ST_PREP) && !no_time && !too_long;
		div_req.dividend = delta;
		div_req.divisor  = elapsed[DW-1:0];
	end

	bav_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quotient)
	);

	// Activity ring and count update
	assign out_free   = !out_valid_q || out_ready;
	assign upd_fire   = (state_q == ST_UPD) && out_free;
	assign active     = (rate_q > thr_q);
	assign count_next = count_q + CW'(active) - CW'(old_flag);
	assign over_floor = count_next - floor_q;

	always_comb begin
		ring_req      = '0;
		ring_req.rd   = (state_q == ST_PREP);
		ring_req.wr   = upd_fire;
		ring_req.flag = active;
	end

	bav_ring #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ring_req),
		.old_flag (old_flag)
	);

	// Volume from the updated count
	always_comb begin
		if (count_next <= floor_q)
			volume_next = '0;
		else if (count_next <= ceil_q)
			volume_next = DW'(over_floor);
		else
			volume_next = full_q;
	end

	// Sequencer and item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_sample_q <= '0;
			prev_time_q   <= '0;
			count_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (no_time || too_long)
						state_q <= ST_UPD;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) begin
						state_q       <= ST_IDLE;
						prev_sample_q <= scaled_q;
						prev_time_q   <= time_q;
						count_q       <= count_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output transaction pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (upd_fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			scaled_q <= product[DW-1:0];
			time_q   <= timestamp_us;
		end
		if (state_q == ST_PREP) begin
			if (no_time)
				rate_q <= bav_pkg::RATE_MAX;
			else if (too_long)
				rate_q <= '0;
		end
		if ((state_q == ST_DIV) && div_done)
			rate_q <= quotient;
		if (upd_fire)
			volume_q <= volume_next;
	end

	assign out_valid = out_valid_q;
	assign volume    = volume_q;

endmodule

>>> hw/rtl/bav_chk.sv
`include "assert_macros.svh"

// Port-level checks for breath_activity_volume
module bav_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [bav_pkg::DATA_W-1:0]     volume
);

	// Held in reset: nothing to deliver and ready for a transaction
	`BAV_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid && in_ready, "reset state wrong")

	// An accepted transaction keeps in_ready low through the set-up state and the divide or update state after it
	`BAV_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready ##1 !in_ready, "ready too soon")

	// A new volume only appears at the end of a busy period
	`BAV_ASSERT(a_out_after_busy, $rose(out_valid) |-> $past(!in_ready), "volume without work")

	// A stalled volume holds
	`BAV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(volume), "volume lost")

endmodule

bind breath_activity_volume bav_chk u_bav_chk (.*);
